// ===== rtl/core/rtd_pkg.sv =====
package rtd_pkg;

  // screen store limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int PX_W       = $clog2(MAX_WIDTH);
  localparam int PY_W       = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 9;

  // datapath widths
  localparam int XY_W   = 12;
  localparam int D_W    = XY_W + 1;
  localparam int Z_W    = 16;
  localparam int COL_W  = 32;
  localparam int EDGE_W = 28;
  localparam int AREA_W = 26;
  localparam int SUM_W  = AREA_W + Z_W;
  localparam int MA_W   = EDGE_W;
  localparam int MB_W   = Z_W + 1;
  localparam int MP_W   = MA_W + MB_W;

  // register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // commands
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // setup sequence steps of the shared multiplier
  localparam logic [3:0] SU_AREA_A = 4'd0;
  localparam logic [3:0] SU_AREA_B = 4'd1;
  localparam logic [3:0] SU_ROW    = 4'd8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_EVAL,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_WR,
    ST_RP_MUL,
    ST_RP_MEM,
    ST_RP_OUT
  } rtd_state_t;

endpackage

// ===== rtl/core/rtd_div.sv =====
module rtd_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [rtd_pkg::SUM_W-1:0]       dividend,
  input  logic [rtd_pkg::AREA_W-1:0]      divisor,
  output logic                            done,
  output logic [rtd_pkg::Z_W-1:0]         quotient
);

  localparam int CNT_W = $clog2(rtd_pkg::Z_W);

  logic [rtd_pkg::AREA_W-1:0] rem_r;
  logic [rtd_pkg::Z_W-1:0]    low_r;
  logic [rtd_pkg::Z_W-1:0]    q_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [rtd_pkg::AREA_W:0]   trial;
  logic [rtd_pkg::AREA_W:0]   diff;
  logic                       qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, low_r[rtd_pkg::Z_W-1]};
    qbit  = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(rtd_pkg::Z_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient stays below 2^Z_W, so the upper part starts under the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[rtd_pkg::SUM_W-1:rtd_pkg::Z_W];
      low_r <= dividend[rtd_pkg::Z_W-1:0];
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= qbit ? diff[rtd_pkg::AREA_W-1:0] : trial[rtd_pkg::AREA_W-1:0];
      low_r <= {low_r[rtd_pkg::Z_W-2:0], 1'b0};
      q_r   <= {q_r[rtd_pkg::Z_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/core/triangle_raster_depth_test.sv =====
// channel | ports                                   | handshake
// input   | start, busy, in_cmd .. in_fill_color    | word taken when start && !busy
// result  | out_valid, out_pixel_color/depth        | one-cycle strobe, no backpressure
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write when valid && ready
//
// After reset a clearing pass writes every store entry, busy high.
// Read word: row base multiply, store read and output register, then the result strobe.
// Draw word: setup steps, then per box pixel an edge test; a pixel inside the triangle
// also takes the shared multiplier x3, the 16-step divider and a write.
// The result side cannot stall; config writes are always taken.
module triangle_raster_depth_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic signed [rtd_pkg::XY_W-1:0]   in_x0,
  input  logic signed [rtd_pkg::XY_W-1:0]   in_y0,
  input  logic [rtd_pkg::Z_W-1:0]           in_z0,
  input  logic signed [rtd_pkg::XY_W-1:0]   in_x1,
  input  logic signed [rtd_pkg::XY_W-1:0]   in_y1,
  input  logic [rtd_pkg::Z_W-1:0]           in_z1,
  input  logic signed [rtd_pkg::XY_W-1:0]   in_x2,
  input  logic signed [rtd_pkg::XY_W-1:0]   in_y2,
  input  logic [rtd_pkg::Z_W-1:0]           in_z2,
  input  logic [rtd_pkg::COL_W-1:0]         in_fill_color,
  output logic                              out_valid,
  output logic [rtd_pkg::COL_W-1:0]         out_pixel_color,
  output logic [rtd_pkg::Z_W-1:0]           out_pixel_depth,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [rtd_pkg::SIZE_W-1:0]        cfg_data
);

  localparam int XY_W   = rtd_pkg::XY_W;
  localparam int D_W    = rtd_pkg::D_W;
  localparam int ADDR_W = rtd_pkg::ADDR_W;
  localparam int PX_W   = rtd_pkg::PX_W;
  localparam int PY_W   = rtd_pkg::PY_W;
  localparam int EDGE_W = rtd_pkg::EDGE_W;

  rtd_pkg::rtd_state_t st_r, st_nxt;

  logic [rtd_pkg::SIZE_W-1:0] scr_w_r, scr_h_r;
  logic [rtd_pkg::SIZE_W-1:0] w_eff, h_eff;

  logic signed [XY_W-1:0] vx_r [3];
  logic signed [XY_W-1:0] vy_r [3];
  logic [rtd_pkg::Z_W-1:0] vz_r [3];
  logic [rtd_pkg::COL_W-1:0] color_r;
  logic [PX_W-1:0] px_r, minx_r, maxx_r;
  logic [PY_W-1:0] py_r, miny_r, maxy_r;
  logic rd_in_r;
  logic [ADDR_W-1:0] rowbase_r;
  logic [ADDR_W-1:0] pix_addr;
  logic [3:0] step_r;
  logic [ADDR_W-1:0] clr_r;

  logic signed [EDGE_W-1:0] er_r [3];
  logic signed [EDGE_W-1:0] ec_r [3];
  logic signed [rtd_pkg::MP_W-1:0] acc_r;
  logic signed [rtd_pkg::MP_W-1:0] area_r;

  logic signed [D_W-1:0] dxe [3];
  logic signed [D_W-1:0] dye [3];
  logic signed [D_W-1:0] pxa [3];
  logic signed [D_W-1:0] pya [3];

  logic signed [rtd_pkg::MA_W-1:0] mul_a;
  logic signed [rtd_pkg::MB_W-1:0] mul_b;
  logic signed [rtd_pkg::MP_W-1:0] mul_p;

  logic signed [D_W-1:0] minx_c, maxx_c, miny_c, maxy_c, w_s, h_s;
  logic signed [XY_W-1:0] mnx, mxx, mny, mxy;
  logic box_empty, rd_in;

  logic covered, last_pix, area_ok;
  logic [1:0] mi;

  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [rtd_pkg::COL_W-1:0] mem_wcolor, color_rd_r;
  logic [rtd_pkg::Z_W-1:0] mem_wdepth, depth_rd_r;
  logic div_start, div_done;
  logic [rtd_pkg::Z_W-1:0] div_q;

  logic [rtd_pkg::COL_W-1:0] color_store [rtd_pkg::STORE_SIZE];
  logic [rtd_pkg::Z_W-1:0]   depth_store [rtd_pkg::STORE_SIZE];

  logic out_valid_r;
  logic [rtd_pkg::COL_W-1:0] out_color_r;
  logic [rtd_pkg::Z_W-1:0] out_depth_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= rtd_pkg::SIZE_W'(rtd_pkg::MAX_WIDTH);
      scr_h_r <= rtd_pkg::SIZE_W'(rtd_pkg::MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtd_pkg::CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        rtd_pkg::CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective screen size
  always_comb begin
    w_eff = scr_w_r;
    if (scr_w_r == '0) w_eff = rtd_pkg::SIZE_W'(1);
    else if (scr_w_r > rtd_pkg::SIZE_W'(rtd_pkg::MAX_WIDTH))
      w_eff = rtd_pkg::SIZE_W'(rtd_pkg::MAX_WIDTH);
    h_eff = scr_h_r;
    if (scr_h_r == '0) h_eff = rtd_pkg::SIZE_W'(1);
    else if (scr_h_r > rtd_pkg::SIZE_W'(rtd_pkg::MAX_HEIGHT))
      h_eff = rtd_pkg::SIZE_W'(rtd_pkg::MAX_HEIGHT);
    w_s = D_W'($signed({1'b0, w_eff}));
    h_s = D_W'($signed({1'b0, h_eff}));
  end

  // bounding box and read bounds of the incoming word
  always_comb begin
    mnx = (in_x0 < in_x1) ? in_x0 : in_x1;
    mnx = (mnx < in_x2) ? mnx : in_x2;
    mxx = (in_x0 > in_x1) ? in_x0 : in_x1;
    mxx = (mxx > in_x2) ? mxx : in_x2;
    mny = (in_y0 < in_y1) ? in_y0 : in_y1;
    mny = (mny < in_y2) ? mny : in_y2;
    mxy = (in_y0 > in_y1) ? in_y0 : in_y1;
    mxy = (mxy > in_y2) ? mxy : in_y2;
    minx_c = (mnx < 0) ? '0 : D_W'(mnx);
    miny_c = (mny < 0) ? '0 : D_W'(mny);
    maxx_c = (D_W'(mxx) > D_W'(w_s - 1)) ? D_W'(w_s - 1) : D_W'(mxx);
    maxy_c = (D_W'(mxy) > D_W'(h_s - 1)) ? D_W'(h_s - 1) : D_W'(mxy);
    box_empty = (minx_c > maxx_c) || (miny_c > maxy_c);
    rd_in = (in_x0 >= 0) && (D_W'(in_x0) < w_s) && (in_y0 >= 0) && (D_W'(in_y0) < h_s);
  end

  // edge terms; edge i runs from vertex i to vertex i+1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dxe[i] = D_W'(vx_r[(i + 1) % 3]) - D_W'(vx_r[i]);
      dye[i] = D_W'(vy_r[(i + 1) % 3]) - D_W'(vy_r[i]);
      pxa[i] = D_W'($signed({1'b0, minx_r})) - D_W'(vx_r[i]);
      pya[i] = D_W'($signed({1'b0, miny_r})) - D_W'(vy_r[i]);
    end
  end

  assign covered  = !ec_r[0][EDGE_W-1] && !ec_r[1][EDGE_W-1] && !ec_r[2][EDGE_W-1];
  assign last_pix = (px_r == maxx_r) && (py_r == maxy_r);
  assign area_ok  = (area_r > 0);
  assign pix_addr = rowbase_r + ADDR_W'(px_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mi    = 2'(step_r[2:1] - 2'd1);
    unique case (st_r)
      rtd_pkg::ST_SETUP: begin
        if (step_r == rtd_pkg::SU_AREA_A) begin
          mul_a = rtd_pkg::MA_W'(dxe[0]);
          mul_b = rtd_pkg::MB_W'(D_W'(vy_r[2]) - D_W'(vy_r[0]));
        end else if (step_r == rtd_pkg::SU_AREA_B) begin
          mul_a = rtd_pkg::MA_W'(dye[0]);
          mul_b = rtd_pkg::MB_W'(D_W'(vx_r[2]) - D_W'(vx_r[0]));
        end else if (step_r == rtd_pkg::SU_ROW) begin
          mul_a = rtd_pkg::MA_W'($signed({1'b0, miny_r}));
          mul_b = rtd_pkg::MB_W'($signed({1'b0, w_eff}));
        end else if (!step_r[0]) begin
          mul_a = rtd_pkg::MA_W'(dxe[mi]);
          mul_b = rtd_pkg::MB_W'(pya[mi]);
        end else begin
          mul_a = rtd_pkg::MA_W'(dye[mi]);
          mul_b = rtd_pkg::MB_W'(pxa[mi]);
        end
      end
      rtd_pkg::ST_MUL: begin
        // vertex k takes the edge opposite it
        case (step_r[1:0])
          2'd0: begin
            mul_a = ec_r[1];
            mul_b = rtd_pkg::MB_W'($signed({1'b0, vz_r[0]}));
          end
          2'd1: begin
            mul_a = ec_r[2];
            mul_b = rtd_pkg::MB_W'($signed({1'b0, vz_r[1]}));
          end
          default: begin
            mul_a = ec_r[0];
            mul_b = rtd_pkg::MB_W'($signed({1'b0, vz_r[2]}));
          end
        endcase
      end
      rtd_pkg::ST_RP_MUL: begin
        mul_a = rtd_pkg::MA_W'(vy_r[0]);
        mul_b = rtd_pkg::MB_W'($signed({1'b0, w_eff}));
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rtd_pkg::ST_CLEAR:
        if (clr_r == ADDR_W'(rtd_pkg::STORE_SIZE - 1)) st_nxt = rtd_pkg::ST_IDLE;
      rtd_pkg::ST_IDLE:
        if (start) begin
          if (in_cmd == rtd_pkg::CMD_READ) st_nxt = rtd_pkg::ST_RP_MUL;
          else if (!box_empty) st_nxt = rtd_pkg::ST_SETUP;
        end
      rtd_pkg::ST_SETUP:
        if (step_r == rtd_pkg::SU_ROW)
          st_nxt = area_ok ? rtd_pkg::ST_EVAL : rtd_pkg::ST_IDLE;
      rtd_pkg::ST_EVAL:
        if (covered) st_nxt = rtd_pkg::ST_MUL;
        else if (last_pix) st_nxt = rtd_pkg::ST_IDLE;
      rtd_pkg::ST_MUL:
        if (step_r == 4'd2) st_nxt = rtd_pkg::ST_DIVGO;
      rtd_pkg::ST_DIVGO: st_nxt = rtd_pkg::ST_DIV;
      rtd_pkg::ST_DIV:
        if (div_done) st_nxt = rtd_pkg::ST_WR;
      rtd_pkg::ST_WR:
        st_nxt = last_pix ? rtd_pkg::ST_IDLE : rtd_pkg::ST_EVAL;
      rtd_pkg::ST_RP_MUL: st_nxt = rtd_pkg::ST_RP_MEM;
      rtd_pkg::ST_RP_MEM: st_nxt = rtd_pkg::ST_RP_OUT;
      rtd_pkg::ST_RP_OUT: st_nxt = rtd_pkg::ST_IDLE;
      default: st_nxt = rtd_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy       = (st_r != rtd_pkg::ST_IDLE);
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = pix_addr;
    mem_raddr  = pix_addr;
    mem_wcolor = color_r;
    mem_wdepth = div_q;
    div_start  = 1'b0;
    unique case (st_r)
      rtd_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_r;
        mem_wcolor = '0;
        mem_wdepth = '1;
      end
      rtd_pkg::ST_EVAL:   mem_re = covered;
      rtd_pkg::ST_RP_MEM: mem_re = 1'b1;
      rtd_pkg::ST_DIVGO:  div_start = 1'b1;
      rtd_pkg::ST_WR:     mem_we = (div_q < depth_rd_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rtd_pkg::ST_CLEAR;
      clr_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      step_r      <= (st_nxt != st_r) ? '0 : step_r + 1'b1;
      out_valid_r <= (st_r == rtd_pkg::ST_RP_OUT);
      if (st_r == rtd_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      rtd_pkg::ST_IDLE: begin
        if (start) begin
          vx_r[0] <= in_x0; vy_r[0] <= in_y0; vz_r[0] <= in_z0;
          vx_r[1] <= in_x1; vy_r[1] <= in_y1; vz_r[1] <= in_z1;
          vx_r[2] <= in_x2; vy_r[2] <= in_y2; vz_r[2] <= in_z2;
          color_r <= in_fill_color;
          rd_in_r <= rd_in;
          minx_r  <= minx_c[PX_W-1:0];
          maxx_r  <= maxx_c[PX_W-1:0];
          miny_r  <= miny_c[PY_W-1:0];
          maxy_r  <= maxy_c[PY_W-1:0];
          px_r    <= (in_cmd == rtd_pkg::CMD_READ) ? in_x0[PX_W-1:0] : minx_c[PX_W-1:0];
          py_r    <= miny_c[PY_W-1:0];
        end
      end
      rtd_pkg::ST_SETUP: begin
        if (step_r == rtd_pkg::SU_ROW) begin
          rowbase_r <= mul_p[ADDR_W-1:0];
        end else if (step_r == rtd_pkg::SU_AREA_B) begin
          area_r <= acc_r - mul_p;
        end else if (!step_r[0]) begin
          acc_r <= mul_p;
        end else begin
          er_r[mi] <= EDGE_W'(acc_r - mul_p);
          ec_r[mi] <= EDGE_W'(acc_r - mul_p);
        end
        if (step_r == rtd_pkg::SU_AREA_A) acc_r <= mul_p;
      end
      rtd_pkg::ST_MUL: begin
        acc_r <= (step_r == 4'd0) ? mul_p : acc_r + mul_p;
      end
      rtd_pkg::ST_RP_MUL: rowbase_r <= mul_p[ADDR_W-1:0];
      rtd_pkg::ST_RP_OUT: begin
        out_color_r <= rd_in_r ? color_rd_r : '0;
        out_depth_r <= rd_in_r ? depth_rd_r : '1;
      end
      default: ;
    endcase
    // step to the next pixel of the box
    if ((st_r == rtd_pkg::ST_EVAL && !covered) || st_r == rtd_pkg::ST_WR) begin
      if (px_r == maxx_r) begin
        px_r      <= minx_r;
        py_r      <= py_r + 1'b1;
        rowbase_r <= rowbase_r + ADDR_W'(w_eff);
        for (int i = 0; i < 3; i++) begin
          er_r[i] <= er_r[i] + EDGE_W'(dxe[i]);
          ec_r[i] <= er_r[i] + EDGE_W'(dxe[i]);
        end
      end else begin
        px_r <= px_r + 1'b1;
        for (int i = 0; i < 3; i++) ec_r[i] <= ec_r[i] - EDGE_W'(dye[i]);
      end
    end
  end

  // color and depth stores
  always_ff @(posedge clk) begin
    if (mem_we) begin
      color_store[mem_waddr] <= mem_wcolor;
      depth_store[mem_waddr] <= mem_wdepth;
    end
    if (mem_re) begin
      color_rd_r <= color_store[mem_raddr];
      depth_rd_r <= depth_store[mem_raddr];
    end
  end

  rtd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r[rtd_pkg::SUM_W-1:0]),
    .divisor  (area_r[rtd_pkg::AREA_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;
  assign out_pixel_depth = out_depth_r;

  // checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> (st_r == rtd_pkg::ST_IDLE))
    else $error("word taken outside idle");

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r == rtd_pkg::ST_RP_OUT))
    else $error("result strobe without a read");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == rtd_pkg::ST_DIV))
    else $error("divider finished outside wait state");

  a_wr_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && st_r != rtd_pkg::ST_CLEAR) |->
      (px_r >= minx_r && px_r <= maxx_r && py_r >= miny_r && py_r <= maxy_r))
    else $error("pixel write outside the box");

endmodule
